// ===== hdl/ffgs_pkg.sv =====
// Shared types and constants for the FASTA/FASTQ gap splitter.
`timescale 1ns / 1ps
package ffgs_pkg;

  localparam int COUNT_WIDTH_DEF = 32;
  localparam int RES_DEPTH       = 4;

  typedef struct packed {
    logic       action;
    logic [7:0] byte_value;
  } in_item_t;

  typedef struct packed {
    logic        kind;
    logic [31:0] record_number;
    logic [31:0] run_start;
    logic [31:0] run_end;
    logic [3:0]  error_code;
    logic [31:0] line_number;
    logic        last;
  } out_item_t;

  // results of one input item, at most two
  typedef struct packed {
    logic [1:0] n;
    out_item_t  r0;
    out_item_t  r1;
  } ffgs_res_t;

  localparam logic ACT_DATA = 1'b0;
  localparam logic ACT_END  = 1'b1;

  localparam logic KIND_INTERVAL = 1'b0;
  localparam logic KIND_ERROR    = 1'b1;

  localparam logic [7:0] CH_N_UP = 8'h4E;
  localparam logic [7:0] CH_N_LO = 8'h6E;
  localparam logic [7:0] CH_GT   = 8'h3E;
  localparam logic [7:0] CH_AT   = 8'h40;
  localparam logic [7:0] CH_PLUS = 8'h2B;
  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_LF   = 8'h0A;

  localparam logic [3:0] ERR_GT_IN_FASTQ   = 4'd0;
  localparam logic [3:0] ERR_AT_IN_FASTA   = 4'd1;
  localparam logic [3:0] ERR_CR_NO_LF      = 4'd2;
  localparam logic [3:0] ERR_STRAY_BYTE    = 4'd3;
  localparam logic [3:0] ERR_END_IN_NAME   = 4'd4;
  localparam logic [3:0] ERR_EMPTY_SEQ     = 4'd5;
  localparam logic [3:0] ERR_SEQ_LONG      = 4'd6;
  localparam logic [3:0] ERR_NO_PLUS       = 4'd7;
  localparam logic [3:0] ERR_EMPTY_QUAL    = 4'd8;
  localparam logic [3:0] ERR_QUAL_LINE_LONG = 4'd9;
  localparam logic [3:0] ERR_QUAL_TOO_LONG = 4'd10;
  localparam logic [3:0] ERR_QUAL_SHORT    = 4'd11;
  localparam logic [3:0] ERR_EMPTY_NAME    = 4'd12;
  localparam logic [3:0] ERR_NO_RECORD     = 4'd13;

  function automatic logic is_space(input logic [7:0] c);
    return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic logic is_graph(input logic [7:0] c);
    return (c >= 8'h21) && (c <= 8'h7E);
  endfunction

endpackage

// ===== hdl/ffgs_parse.sv =====
// Record parser: state registers and per-byte next-state and result logic.
`timescale 1ns / 1ps
module ffgs_parse #(
  parameter int COUNT_WIDTH = ffgs_pkg::COUNT_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_fire,
  input  ffgs_pkg::in_item_t in_data,
  output ffgs_pkg::ffgs_res_t res
);
  import ffgs_pkg::*;

  localparam int CW = COUNT_WIDTH;
  typedef logic [CW-1:0] cnt_t;
  localparam cnt_t CMAX = '1;
  localparam cnt_t ONE  = cnt_t'(1);

  typedef enum logic [3:0] {
    PH_OUT, PH_CR, PH_NAME_START, PH_NAME0, PH_NAME1, PH_NAME_SKIP,
    PH_SEQ_START, PH_SEQ_LINE, PH_SEQ_END, PH_PLUS_SKIP, PH_QUAL_START,
    PH_QUAL_LINE
  } phase_t;

  typedef enum logic [1:0] {FMT_NONE, FMT_FASTA, FMT_FASTQ} fmt_t;

  function automatic cnt_t inc(input cnt_t x);
    return (x == CMAX) ? x : x + ONE;
  endfunction

  function automatic cnt_t dec(input cnt_t x);
    return (x == '0) ? x : x - ONE;
  endfunction

  function automatic cnt_t sat_add(input cnt_t a, input cnt_t b);
    logic [CW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[CW] ? CMAX : s[CW-1:0];
  endfunction

  phase_t ph_r, ph_nxt;
  fmt_t   fmt_r, fmt_nxt;
  logic   rc_r, rc_nxt, inr_r, inr_nxt, nhc_r, nhc_nxt;
  cnt_t   rb_r, rb_nxt, np_r, np_nxt, sl_r, sl_nxt, ql_r, ql_nxt;
  cnt_t   fl_r, fl_nxt, lch_r, lch_nxt, lgr_r, lgr_nxt;
  cnt_t   rs_r, rs_nxt, ln_r, ln_nxt;

  logic [1:0] n;
  out_item_t  r0, r1, it;
  logic       [7:0] c;
  logic       done;
  cnt_t       ll;

  function automatic out_item_t mk_int(input cnt_t rs, input cnt_t s, input cnt_t e);
    out_item_t o;
    o = '0;
    o.kind          = KIND_INTERVAL;
    o.record_number = 32'(dec(rs));
    o.run_start     = 32'(s);
    o.run_end       = 32'(e);
    return o;
  endfunction

  function automatic out_item_t mk_err(input logic [3:0] code, input cnt_t line);
    out_item_t o;
    o = '0;
    o.kind        = KIND_ERROR;
    o.error_code  = code;
    o.line_number = 32'(line);
    return o;
  endfunction

  always_comb begin
    ph_nxt = ph_r;  fmt_nxt = fmt_r; rc_nxt = rc_r; inr_nxt = inr_r; nhc_nxt = nhc_r;
    rb_nxt = rb_r;  np_nxt = np_r;   sl_nxt = sl_r; ql_nxt = ql_r;   fl_nxt = fl_r;
    lch_nxt = lch_r; lgr_nxt = lgr_r; rs_nxt = rs_r; ln_nxt = ln_r;
    n = 2'd0; r0 = '0; r1 = '0; it = '0; done = 1'b0; ll = '0;
    c = in_data.byte_value;

    if (in_data.action == ACT_DATA) begin
      case (ph_r)
        PH_CR: begin
          ph_nxt = PH_OUT;
          if (c == CH_LF) ln_nxt = inc(ln_nxt);
          else begin it = mk_err(ERR_CR_NO_LF, ln_nxt); r0 = it; n = 2'd1; end
        end
        PH_NAME_START, PH_NAME0, PH_NAME1: begin
          if (ph_r == PH_NAME_START) begin
            if (rc_nxt) begin
              if (!inr_nxt) begin
                if (!nhc_nxt) begin
                  r0 = mk_err(ERR_EMPTY_NAME, ln_nxt); n = 2'd1; done = 1'b1;
                end else begin
                  r0 = mk_int(rs_nxt, rb_nxt, dec(np_nxt)); n = 2'd1;
                end
              end
              if (!done) begin nhc_nxt = 1'b0; rc_nxt = 1'b0; end
            end
            if (!done) ph_nxt = PH_NAME0;
          end
          if (!done) begin
            if (!is_space(c)) begin
              nhc_nxt = 1'b1;
              ph_nxt  = PH_NAME1;
            end else if (ph_nxt == PH_NAME1 || c == CH_LF) begin
              if (c == CH_LF) begin
                ph_nxt = PH_SEQ_START; sl_nxt = '0; ql_nxt = '0; fl_nxt = '0;
                rb_nxt = ONE; np_nxt = ONE; inr_nxt = 1'b1;
                ln_nxt = inc(ln_nxt); rs_nxt = inc(rs_nxt);
              end else ph_nxt = PH_NAME_SKIP;
            end
          end
        end
        PH_NAME_SKIP: begin
          if (c == CH_LF) begin
            ph_nxt = PH_SEQ_START; sl_nxt = '0; ql_nxt = '0; fl_nxt = '0;
            rb_nxt = ONE; np_nxt = ONE; inr_nxt = 1'b1;
            ln_nxt = inc(ln_nxt); rs_nxt = inc(rs_nxt);
          end
        end
        PH_SEQ_START, PH_SEQ_LINE: begin
          if (ph_r == PH_SEQ_START) begin
            if (fmt_r == FMT_FASTA) begin
              if (c == CH_LF) begin ph_nxt = PH_OUT; ln_nxt = inc(ln_nxt); done = 1'b1; end
              else if (c == CH_GT) begin ph_nxt = PH_NAME_START; done = 1'b1; end
            end else if (fmt_r == FMT_FASTQ) begin
              if (c == CH_PLUS) begin ph_nxt = PH_PLUS_SKIP; done = 1'b1; end
              else if (c == CH_LF) begin
                r0 = mk_err(ERR_EMPTY_SEQ, ln_nxt); n = 2'd1; done = 1'b1;
              end
            end
            if (!done) begin
              lch_nxt = '0; lgr_nxt = '0;
              if (fmt_r == FMT_FASTA) rc_nxt = 1'b1;
              ph_nxt = PH_SEQ_LINE;
            end
          end
          if (!done && ph_r == PH_SEQ_LINE && c == CH_LF) begin
            // line end
            ll = inc(lch_nxt); lch_nxt = ll; ph_nxt = PH_SEQ_START;
            sl_nxt = sat_add(sl_nxt, lgr_nxt);
            if (fl_nxt == '0) begin
              fl_nxt = ll; ln_nxt = inc(ln_nxt);
            end else if (fl_nxt > ll) begin
              ph_nxt = (fmt_r == FMT_FASTQ) ? PH_SEQ_END : PH_OUT;
              ln_nxt = inc(ln_nxt);
            end else if (fl_nxt < ll) begin
              r0 = mk_err(ERR_SEQ_LONG, ln_nxt); n = 2'd1;
            end else ln_nxt = inc(ln_nxt);
          end else if (!done) begin
            lch_nxt = inc(lch_nxt); lgr_nxt = inc(lgr_nxt);
            if (is_graph(c)) begin
              if (c == CH_N_UP || c == CH_N_LO) begin
                if (!inr_nxt) begin
                  if (!nhc_nxt) begin
                    r0 = mk_err(ERR_EMPTY_NAME, ln_nxt); n = 2'd1;
                  end else begin
                    r0 = mk_int(rs_nxt, rb_nxt, dec(np_nxt)); n = 2'd1;
                    rb_nxt = np_nxt; np_nxt = inc(np_nxt); inr_nxt = 1'b1;
                  end
                end else begin
                  rb_nxt = inc(rb_nxt); np_nxt = inc(np_nxt);
                end
              end else begin
                if (inr_nxt) begin rb_nxt = np_nxt; inr_nxt = 1'b0; end
                np_nxt = inc(np_nxt);
              end
            end
          end
        end
        PH_SEQ_END: begin
          if (c == CH_PLUS) ph_nxt = PH_PLUS_SKIP;
          else begin r0 = mk_err(ERR_NO_PLUS, ln_nxt); n = 2'd1; end
        end
        PH_PLUS_SKIP: begin
          if (c == CH_LF) begin ph_nxt = PH_QUAL_START; ln_nxt = inc(ln_nxt); end
        end
        PH_QUAL_START: begin
          if (c == CH_LF) begin
            if (!rc_nxt) begin r0 = mk_err(ERR_EMPTY_QUAL, ln_nxt); n = 2'd1; end
            else begin ph_nxt = PH_OUT; ln_nxt = inc(ln_nxt); end
          end else if (c == CH_AT && rc_nxt) begin
            ph_nxt = PH_NAME_START;
          end else begin
            lch_nxt = ONE; ph_nxt = PH_QUAL_LINE;
            lgr_nxt = is_graph(c) ? ONE : '0;
          end
        end
        PH_QUAL_LINE: begin
          if (c == CH_LF) begin
            ll = inc(lch_nxt); lch_nxt = ll; ph_nxt = PH_QUAL_START;
            ql_nxt = sat_add(ql_nxt, lgr_nxt);
            if (fl_nxt < ll) begin r0 = mk_err(ERR_QUAL_LINE_LONG, ln_nxt); n = 2'd1; end
            else if (ql_nxt == sl_nxt) begin rc_nxt = 1'b1; ln_nxt = inc(ln_nxt); end
            else if (ql_nxt > sl_nxt) begin
              r0 = mk_err(ERR_QUAL_TOO_LONG, ln_nxt); n = 2'd1;
            end else if (fl_nxt > ll) begin
              r0 = mk_err(ERR_QUAL_SHORT, ln_nxt); n = 2'd1;
            end else ln_nxt = inc(ln_nxt);
          end else begin
            lch_nxt = inc(lch_nxt);
            if (is_graph(c)) lgr_nxt = inc(lgr_nxt);
          end
        end
        default: begin
          ph_nxt = PH_OUT;
          if (c == CH_GT) begin
            if (fmt_r == FMT_FASTQ) begin r0 = mk_err(ERR_GT_IN_FASTQ, ln_nxt); n = 2'd1; end
            else begin fmt_nxt = FMT_FASTA; ph_nxt = PH_NAME_START; end
          end else if (c == CH_AT) begin
            if (fmt_r == FMT_FASTA) begin r0 = mk_err(ERR_AT_IN_FASTA, ln_nxt); n = 2'd1; end
            else begin fmt_nxt = FMT_FASTQ; ph_nxt = PH_NAME_START; end
          end else if (c == CH_CR) ph_nxt = PH_CR;
          else if (c == CH_LF) ln_nxt = inc(ln_nxt);
          else begin r0 = mk_err(ERR_STRAY_BYTE, ln_nxt); n = 2'd1; end
        end
      endcase
    end else begin
      // end of stream: close the open line, flush, then back to reset state
      case (ph_r)
        PH_CR: begin r0 = mk_err(ERR_CR_NO_LF, ln_nxt); n = 2'd1; end
        PH_NAME0, PH_NAME1: begin r0 = mk_err(ERR_END_IN_NAME, ln_nxt); n = 2'd1; end
        PH_NAME_SKIP: begin
          sl_nxt = '0; ql_nxt = '0; fl_nxt = '0;
          rb_nxt = ONE; np_nxt = ONE; inr_nxt = 1'b1;
          ln_nxt = inc(ln_nxt); rs_nxt = inc(rs_nxt);
        end
        PH_SEQ_LINE: begin
          ll = inc(lch_nxt);
          if (fl_nxt != '0 && fl_nxt < ll) begin
            r0 = mk_err(ERR_SEQ_LONG, ln_nxt); n = 2'd1;
          end else ln_nxt = inc(ln_nxt);
        end
        PH_PLUS_SKIP: ln_nxt = inc(ln_nxt);
        PH_QUAL_LINE: begin
          ll = inc(lch_nxt);
          ql_nxt = sat_add(ql_nxt, lgr_nxt);
          if (fl_nxt < ll) begin r0 = mk_err(ERR_QUAL_LINE_LONG, ln_nxt); n = 2'd1; end
          else if (ql_nxt == sl_nxt) begin rc_nxt = 1'b1; ln_nxt = inc(ln_nxt); end
          else if (ql_nxt > sl_nxt) begin
            r0 = mk_err(ERR_QUAL_TOO_LONG, ln_nxt); n = 2'd1;
          end else if (fl_nxt > ll) begin
            r0 = mk_err(ERR_QUAL_SHORT, ln_nxt); n = 2'd1;
          end else ln_nxt = inc(ln_nxt);
        end
        default: ;
      endcase
      it = '0;
      done = 1'b1;
      if (rc_nxt) begin
        if (!inr_nxt) begin
          if (!nhc_nxt) it = mk_err(ERR_EMPTY_NAME, ln_nxt);
          else it = mk_int(rs_nxt, rb_nxt, dec(np_nxt));
        end else done = 1'b0;
      end else it = mk_err(ERR_NO_RECORD, ln_nxt);
      if (done) begin
        if (n == 2'd0) begin r0 = it; n = 2'd1; end
        else begin r1 = it; n = 2'd2; end
      end
      ph_nxt = PH_OUT;  fmt_nxt = FMT_NONE; rc_nxt = 1'b0; inr_nxt = 1'b1; nhc_nxt = 1'b0;
      rb_nxt = ONE; np_nxt = ONE; sl_nxt = '0; ql_nxt = '0; fl_nxt = '0;
      lch_nxt = '0; lgr_nxt = '0; rs_nxt = '0; ln_nxt = ONE;
    end

    if (n == 2'd1) r0.last = 1'b1;
    if (n == 2'd2) r1.last = 1'b1;
    res.n  = n;
    res.r0 = r0;
    res.r1 = r1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r <= PH_OUT;  fmt_r <= FMT_NONE; rc_r <= 1'b0; inr_r <= 1'b1; nhc_r <= 1'b0;
      rb_r <= ONE; np_r <= ONE; sl_r <= '0; ql_r <= '0; fl_r <= '0;
      lch_r <= '0; lgr_r <= '0; rs_r <= '0; ln_r <= ONE;
    end else if (in_fire) begin
      ph_r <= ph_nxt;  fmt_r <= fmt_nxt; rc_r <= rc_nxt; inr_r <= inr_nxt; nhc_r <= nhc_nxt;
      rb_r <= rb_nxt; np_r <= np_nxt; sl_r <= sl_nxt; ql_r <= ql_nxt; fl_r <= fl_nxt;
      lch_r <= lch_nxt; lgr_r <= lgr_nxt; rs_r <= rs_nxt; ln_r <= ln_nxt;
    end
  end

endmodule

// ===== hdl/fasta_fastq_gap_splitter_core.sv =====
// Top level: FASTA/FASTQ parser with non-N interval and error result queue.
// Results are written into the result queue before they appear on the output.
// Throughput: one byte per cycle while in_stall is low; each byte yields zero to two results,
// which leave through a four-entry result queue at one per cycle while out_stall is low.
// Input stalls while the queue holds more than two results.
// Reset (rst_n low, synchronous) returns the parser to outside-record and
// empties the queue.
`timescale 1ns / 1ps
module fasta_fastq_gap_splitter_core #(
  parameter int COUNT_WIDTH = ffgs_pkg::COUNT_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  ffgs_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output ffgs_pkg::out_item_t out_data
);
  import ffgs_pkg::*;

  localparam int AW = $clog2(RES_DEPTH);

  ffgs_res_t    res;
  logic         in_fire, out_fire;
  out_item_t    q_mem [RES_DEPTH];
  logic [AW-1:0] wp_r, rp_r;
  logic [AW:0]  cnt_r;

  assign in_stall  = cnt_r > (AW+1)'(RES_DEPTH - 2);
  assign in_fire   = in_valid && !in_stall;
  assign out_valid = cnt_r != '0;
  assign out_fire  = out_valid && !out_stall;
  assign out_data  = q_mem[rp_r];

  ffgs_parse #(.COUNT_WIDTH(COUNT_WIDTH)) u_parse (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_fire (in_fire),
    .in_data (in_data),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (in_fire) begin
      if (res.n != 2'd0) q_mem[wp_r] <= res.r0;
      if (res.n == 2'd2) q_mem[wp_r + AW'(1)] <= res.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (in_fire) wp_r <= wp_r + AW'(res.n);
      if (out_fire) rp_r <= rp_r + AW'(1);
      cnt_r <= cnt_r + (in_fire ? (AW+1)'(res.n) : '0) - (AW+1)'(out_fire);
    end
  end

endmodule

// ===== hdl/ffgs_checker.sv =====
// Port-level checker for the gap splitter, bound to the top level.
`timescale 1ns / 1ps
module ffgs_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input ffgs_pkg::in_item_t  in_data,
  input logic                out_valid,
  input logic                out_stall,
  input ffgs_pkg::out_item_t out_data
);
  import ffgs_pkg::*;

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_data))
    else $error("stalled input item changed");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  a_interval_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.kind == KIND_INTERVAL |->
      out_data.error_code == 4'd0 && out_data.line_number == 32'd0)
    else $error("interval carries error fields");

  a_error_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.kind == KIND_ERROR |->
      out_data.record_number == 32'd0 && out_data.run_start == 32'd0 &&
      out_data.run_end == 32'd0 && out_data.error_code <= ERR_NO_RECORD)
    else $error("error result malformed");

endmodule

bind fasta_fastq_gap_splitter_core ffgs_checker u_ffgs_checker (.*);

// ===== verif/tb_top.sv =====
// Testbench for the FASTA/FASTQ gap splitter: directed and random record streams against a local parser model.
`timescale 1ns / 1ps
module tb_top;
  import ffgs_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int HOLD_CYCLES    = 300;

  typedef enum int {
    P_OUT, P_CR, P_NAME_START, P_NAME0, P_NAME1, P_NAME_SKIP, P_SEQ_START,
    P_SEQ_LINE, P_SEQ_END, P_PLUS_SKIP, P_QUAL_START, P_QUAL_LINE
  } parse_phase_e;
  typedef enum int {F_NONE, F_FASTA, F_FASTQ} file_fmt_e;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;

  fasta_fastq_gap_splitter_core u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // parser state of the model
  parse_phase_e ph;
  file_fmt_e    fmt;
  logic         rec_done, in_n, name_chars;
  logic [31:0]  run_beg, next_pos, seq_len, q_sum, first_len, line_chars;
  logic [31:0]  line_graph, n_records, line_no;

  out_item_t expected_q[$];
  out_item_t step_q[$];
  int        n_mismatch = 0;
  int        n_items = 0;
  logic      gaps_on = 1'b1;
  logic      hold_start = 1'b0;
  int        hold_left = 0;
  int        idle_cycles = 0;

  function automatic logic [31:0] sinc(logic [31:0] x);
    return (x == 32'hFFFF_FFFF) ? x : x + 32'd1;
  endfunction
  function automatic logic [31:0] sdec(logic [31:0] x);
    return (x == 32'd0) ? x : x - 32'd1;
  endfunction
  function automatic logic [31:0] sadd(logic [31:0] a, logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction
  function automatic logic space_ch(logic [7:0] c);
    return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
  endfunction
  function automatic logic graph_ch(logic [7:0] c);
    return c >= 8'h21 && c <= 8'h7E;
  endfunction

  function automatic void emit(logic k, logic [31:0] rec, logic [31:0] s, logic [31:0] e,
                               logic [3:0] code, logic [31:0] ln);
    out_item_t r;
    if (step_q.size() >= 2) return;
    r = '{kind: k, record_number: rec, run_start: s, run_end: e, error_code: code,
          line_number: ln, last: 1'b0};
    step_q = {step_q, r};
  endfunction
  function automatic void put_run(logic [31:0] s, logic [31:0] e);
    emit(KIND_INTERVAL, sdec(n_records), s, e, 4'd0, 32'd0);
  endfunction
  function automatic void put_err(logic [3:0] code);
    emit(KIND_ERROR, 32'd0, 32'd0, 32'd0, code, line_no);
  endfunction

  function automatic void clear_parser();
    ph = P_OUT; fmt = F_NONE; rec_done = 1'b0; in_n = 1'b1; name_chars = 1'b0;
    run_beg = 32'd1; next_pos = 32'd1; seq_len = 32'd0; q_sum = 32'd0; first_len = 32'd0;
    line_chars = 32'd0; line_graph = 32'd0; n_records = 32'd0; line_no = 32'd1;
  endfunction

  function automatic void end_header();
    ph = P_SEQ_START; seq_len = 32'd0; q_sum = 32'd0; first_len = 32'd0;
    run_beg = 32'd1; next_pos = 32'd1; in_n = 1'b1;
    line_no = sinc(line_no); n_records = sinc(n_records);
  endfunction

  function automatic void name_ch(logic [7:0] c);
    if (!space_ch(c)) begin
      name_chars = 1'b1; ph = P_NAME1;
    end else if (c == CH_LF) begin
      end_header();
    end else if (ph == P_NAME1) begin
      ph = P_NAME_SKIP;
    end
  endfunction

  function automatic void base_ch(logic [7:0] c);
    line_chars = sinc(line_chars);
    line_graph = sinc(line_graph);
    if (!graph_ch(c)) return;
    if (c == CH_N_UP || c == CH_N_LO) begin
      if (!in_n) begin
        if (!name_chars) begin
          put_err(ERR_EMPTY_NAME);
          return;
        end
        put_run(run_beg, sdec(next_pos));
        run_beg = next_pos;
      end else begin
        run_beg = sinc(run_beg);
      end
      next_pos = sinc(next_pos);
      in_n = 1'b1;
    end else begin
      if (in_n) begin
        run_beg = next_pos; in_n = 1'b0;
      end
      next_pos = sinc(next_pos);
    end
  endfunction

  function automatic void seq_eol();
    logic [31:0] ll;
    ll = sinc(line_chars);
    line_chars = ll;
    ph = P_SEQ_START;
    seq_len = sadd(seq_len, line_graph);
    if (first_len == 32'd0) begin
      first_len = ll;
    end else if (first_len > ll) begin
      ph = (fmt == F_FASTQ) ? P_SEQ_END : P_OUT;
    end else if (first_len < ll) begin
      put_err(ERR_SEQ_LONG);
      return;
    end
    line_no = sinc(line_no);
  endfunction

  function automatic void qual_eol();
    logic [31:0] ll;
    ll = sinc(line_chars);
    line_chars = ll;
    ph = P_QUAL_START;
    q_sum = sadd(q_sum, line_graph);
    if (first_len < ll) begin
      put_err(ERR_QUAL_LINE_LONG);
      return;
    end
    if (q_sum == seq_len) rec_done = 1'b1;
    else if (q_sum > seq_len) begin
      put_err(ERR_QUAL_TOO_LONG);
      return;
    end else if (first_len > ll) begin
      put_err(ERR_QUAL_SHORT);
      return;
    end
    line_no = sinc(line_no);
  endfunction

  function automatic void parse_data(logic [7:0] c);
    case (ph)
      P_CR: begin
        ph = P_OUT;
        if (c == CH_LF) line_no = sinc(line_no);
        else put_err(ERR_CR_NO_LF);
      end
      P_NAME_START: begin
        if (rec_done) begin
          if (!in_n) begin
            if (!name_chars) begin
              put_err(ERR_EMPTY_NAME);
              return;
            end
            put_run(run_beg, sdec(next_pos));
          end
          name_chars = 1'b0; rec_done = 1'b0;
        end
        ph = P_NAME0;
        name_ch(c);
      end
      P_NAME0, P_NAME1: name_ch(c);
      P_NAME_SKIP: if (c == CH_LF) end_header();
      P_SEQ_START: begin
        if (fmt == F_FASTA && c == CH_LF) begin
          ph = P_OUT; line_no = sinc(line_no); return;
        end
        if (fmt == F_FASTA && c == CH_GT) begin
          ph = P_NAME_START; return;
        end
        if (fmt == F_FASTQ && c == CH_PLUS) begin
          ph = P_PLUS_SKIP; return;
        end
        if (fmt == F_FASTQ && c == CH_LF) begin
          put_err(ERR_EMPTY_SEQ); return;
        end
        line_chars = 32'd0; line_graph = 32'd0;
        if (fmt == F_FASTA) rec_done = 1'b1;
        ph = P_SEQ_LINE;
        base_ch(c);
      end
      P_SEQ_LINE: if (c == CH_LF) seq_eol(); else base_ch(c);
      P_SEQ_END: if (c == CH_PLUS) ph = P_PLUS_SKIP; else put_err(ERR_NO_PLUS);
      P_PLUS_SKIP: if (c == CH_LF) begin
        ph = P_QUAL_START; line_no = sinc(line_no);
      end
      P_QUAL_START: begin
        if (c == CH_LF) begin
          if (!rec_done) begin
            put_err(ERR_EMPTY_QUAL); return;
          end
          ph = P_OUT; line_no = sinc(line_no); return;
        end
        if (c == CH_AT && rec_done) begin
          ph = P_NAME_START; return;
        end
        line_chars = 32'd0; line_graph = 32'd0; ph = P_QUAL_LINE;
        line_chars = sinc(line_chars);
        if (graph_ch(c)) line_graph = sinc(line_graph);
      end
      P_QUAL_LINE: begin
        if (c == CH_LF) qual_eol();
        else begin
          line_chars = sinc(line_chars);
          if (graph_ch(c)) line_graph = sinc(line_graph);
        end
      end
      default: begin
        ph = P_OUT;
        if (c == CH_GT) begin
          if (fmt == F_FASTQ) put_err(ERR_GT_IN_FASTQ);
          else begin
            fmt = F_FASTA; ph = P_NAME_START;
          end
        end else if (c == CH_AT) begin
          if (fmt == F_FASTA) put_err(ERR_AT_IN_FASTA);
          else begin
            fmt = F_FASTQ; ph = P_NAME_START;
          end
        end else if (c == CH_CR) ph = P_CR;
        else if (c == CH_LF) line_no = sinc(line_no);
        else put_err(ERR_STRAY_BYTE);
      end
    endcase
  endfunction

  function automatic void parse_end();
    case (ph)
      P_CR: put_err(ERR_CR_NO_LF);
      P_NAME0, P_NAME1: put_err(ERR_END_IN_NAME);
      P_NAME_SKIP: end_header();
      P_SEQ_LINE: seq_eol();
      P_PLUS_SKIP: line_no = sinc(line_no);
      P_QUAL_LINE: qual_eol();
      default: ;
    endcase
    if (rec_done) begin
      if (!in_n) begin
        if (!name_chars) put_err(ERR_EMPTY_NAME);
        else put_run(run_beg, sdec(next_pos));
      end
    end else begin
      put_err(ERR_NO_RECORD);
    end
    clear_parser();
  endfunction

  function automatic void predict_item(in_item_t it);
    out_item_t r;
    step_q.delete();
    if (it.action == ACT_DATA) parse_data(it.byte_value);
    else parse_end();
    if (step_q.size() > 0) step_q[step_q.size() - 1].last = 1'b1;
    while (step_q.size() > 0) begin
      r = step_q.pop_front();
      expected_q = {expected_q, r};
    end
  endfunction

  // sender: one item per call, with random gaps while gaps_on is set
  task automatic send_item(logic act, logic [7:0] b);
    in_item_t it;
    it = '{action: act, byte_value: b};
    while (gaps_on && $urandom_range(99) < 35) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_item(it);
    n_items++;
  endtask

  task automatic send_str(string s, int noise_pct);
    for (int i = 0; i < s.len(); i++) begin
      if ($urandom_range(99) < noise_pct) send_item(ACT_DATA, 8'($urandom_range(255)));
      else send_item(ACT_DATA, s[i]);
    end
  endtask

  task automatic end_stream();
    send_item(ACT_END, 8'($urandom_range(255)));
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    wait (expected_q.size() == 0);
    repeat (3) @(posedge clk);
  endtask

  function automatic string rand_name();
    string s;
    int n;
    s = "";
    n = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 4);
    for (int i = 0; i < n; i++) s = {s, string'(8'($urandom_range(8'h21, 8'h7E)))};
    if ($urandom_range(3) == 0) s = {s, " d"};
    return {s, "\n"};
  endfunction

  function automatic string rand_bases(int len, int w);
    string s, alpha;
    int k;
    alpha = "ACGTNNnn";
    s = "";
    for (int i = 0; i < len; i++) begin
      k = $urandom_range(19);
      if (k == 0) s = {s, string'(8'($urandom_range(8'h21, 8'h7E)))};
      else if (k == 1) s = {s, " "};
      else s = {s, string'(alpha[$urandom_range(7)])};
      if ((i + 1) % w == 0 || i == len - 1) s = {s, "\n"};
    end
    return s;
  endfunction

  function automatic string rand_qual(int len, int w);
    string s;
    s = "";
    for (int i = 0; i < len; i++) begin
      s = {s, string'(8'($urandom_range(8'h21, 8'h7E)))};
      if ((i + 1) % w == 0 || i == len - 1) s = {s, "\n"};
    end
    return s;
  endfunction

  task automatic send_file(logic fastq, int noise_pct);
    int nrec, w, len;
    string s;
    nrec = $urandom_range(1, 4);
    s = "";
    for (int r = 0; r < nrec; r++) begin
      w = $urandom_range(1, 8);
      len = $urandom_range(1, 20);
      s = {s, fastq ? "@" : ">", rand_name(), rand_bases(len, w)};
      if (fastq) s = {s, "+", ($urandom_range(1) ? "x" : ""), "\n", rand_qual(len, w)};
      if ($urandom_range(4) == 0) s = {s, "\n\r\n"};
    end
    send_str(s, noise_pct);
    if ($urandom_range(19) == 0) send_str("\r", 0);
    end_stream();
  endtask

  // receiver: random stalls while gaps_on is set, plus an occasional long hold-off
  always @(posedge clk) begin
    if (hold_start) hold_left <= HOLD_CYCLES;
    else if (hold_left > 0) hold_left <= hold_left - 1;
    out_stall <= hold_start || hold_left > 1 || (gaps_on && $urandom_range(99) < 35);
  end

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= 10) $display("unexpected result %p", out_data);
      end else begin
        want = expected_q.pop_front();
        if (out_data !== want) begin
          n_mismatch++;
          if (n_mismatch <= 10) $display("mismatch: expected %p actual %p", want, out_data);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic test_directed();
    send_str(">a\nNACn\nAG\n", 0);
    end_stream();
    send_str("@q\nAC\n+\n!~\n", 0);
    end_stream();
    send_str("x\r\n\ry@>", 0);
    send_str(">\nAN", 0);
    end_stream();
    send_str(">ab", 0);
    end_stream();
    end_stream();
  endtask

  task automatic test_hold_off();
    in_valid <= 1'b0;
    hold_start <= 1'b1;
    @(posedge clk);
    hold_start <= 1'b0;
    send_file(1'b0, 0);
    send_file(1'b1, 0);
    wait_drained();
  endtask

  task automatic test_random();
    int f;
    f = 0;
    while (n_items < 720) begin
      gaps_on <= !(f >= 6 && f < 10);
      send_file(1'($urandom_range(1)), ($urandom_range(3) == 0) ? 4 : 0);
      if (f % 7 == 3) wait_drained();
      f++;
    end
    gaps_on <= 1'b1;
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    clear_parser();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_hold_off();
    test_random();
    test_hold_off();
    wait_drained();
    repeat (10) @(posedge clk);
    if (n_mismatch == 0 && expected_q.size() == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/ffgs_pkg.sv
hdl/ffgs_parse.sv
hdl/fasta_fastq_gap_splitter_core.sv
hdl/ffgs_checker.sv
verif/tb_top.sv
